/* rtl/core/tp3_pkg.sv */
// Shared types, constants and tables for the 3D turtle pose interpreter.
// Used by tp3_ctrl, tp3_dp and the top level; depends on nothing.
`default_nettype none

package tp3_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam int MODE_W = 4;
  localparam int AMT_W  = 24;
  localparam int PW     = 32;             // position, Q16.16
  localparam int HW     = 18;             // heading, Q1.16
  localparam int ZW     = 26;             // angle in 1/4096 degree
  localparam int CW     = 28;             // CORDIC vector components
  localparam int EW     = 26;             // heading with 8 guard bits
  localparam int SW     = 2 * EW;         // sum of squares
  localparam int LW     = SW / 2;         // vector length
  localparam int QW     = 18;             // quotient bits of one division
  localparam int NW     = EW + 17;        // division numerator
  localparam int FPW    = HW + AMT_W;     // forward product
  localparam int GW     = CW + 18;        // gain product
  localparam int RES_W  = 3 * PW + 3 * HW + 1 + 5;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  typedef logic signed [AMT_W-1:0] amt_t;
  typedef logic signed [PW-1:0]    pos_t;
  typedef logic signed [HW-1:0]    head_t;
  typedef logic signed [ZW-1:0]    z_t;
  typedef logic signed [CW-1:0]    cv_t;
  typedef logic signed [EW-1:0]    e_t;
  typedef logic [SW-1:0]           sq_t;
  typedef logic [NW-1:0]           num_t;
  typedef logic [LW:0]             rem_t;
  typedef logic signed [FPW:0]     fw_t;
  typedef logic signed [PW+1:0]    ps_t;

  localparam z_t DEG360     = 26'sd1474560;
  localparam z_t DEG180     = 26'sd737280;
  localparam z_t NEG_DEG180 = -26'sd737280;
  localparam z_t DEG90      = 26'sd368640;
  localparam z_t NEG_DEG90  = -26'sd368640;

  localparam logic signed [17:0] CORDIC_GAIN = 18'sd39797;
  localparam logic [QW-1:0]      Q_ONE       = 18'd65536;
  localparam head_t              HEAD_ONE    = 18'sd65536;

  localparam logic [4:0] CORDIC_LAST = 5'd15;
  localparam logic [4:0] ROOT_LAST   = 5'd25;
  localparam logic [4:0] DIV_LAST    = 5'd17;
  localparam logic [4:0] GAIN_LAST   = 5'd3;
  localparam logic [4:0] SQ_LAST     = 5'd3;
  localparam logic [1:0] AXIS_LAST   = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_FWD      = 4'd0,
    MODE_YAW_L    = 4'd1,
    MODE_YAW_R    = 4'd2,
    MODE_PITCH_DN = 4'd3,
    MODE_PITCH_UP = 4'd4,
    MODE_ROLL_L   = 4'd5,
    MODE_ROLL_R   = 4'd6,
    MODE_TURN     = 4'd7,
    MODE_PUSH     = 4'd8,
    MODE_POP      = 4'd9
  } mode_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_FMUL, OP_FADD, OP_REDUCE, OP_FOLD, OP_CORDIC,
    OP_GMUL, OP_GWR, OP_SQ, OP_SQACC, OP_RINIT, OP_RSTEP, OP_DINIT,
    OP_DSTEP, OP_DWR, OP_NEG, OP_PUSH, OP_POP_RD, OP_POP_WR, OP_FAULT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FMUL, ST_FADD, ST_RED, ST_CORD, ST_GAIN, ST_SQ, ST_RINIT,
    ST_ROOT, ST_DCHK, ST_DINIT, ST_DIV, ST_DWR, ST_NEG, ST_PUSH, ST_POP,
    ST_POPW, ST_OUT
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;
    logic [4:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic red_done;
    logic len_zero;
    logic stk_full;
    logic stk_empty;
  } dp_stat_t;

  // Arctangent of 2^-i in 1/4096 degree units.
  function automatic logic [17:0] atan_lut(input logic [3:0] i);
    unique case (i)
      4'd0:  atan_lut = 18'd184320;
      4'd1:  atan_lut = 18'd108810;
      4'd2:  atan_lut = 18'd57492;
      4'd3:  atan_lut = 18'd29184;
      4'd4:  atan_lut = 18'd14649;
      4'd5:  atan_lut = 18'd7331;
      4'd6:  atan_lut = 18'd3667;
      4'd7:  atan_lut = 18'd1833;
      4'd8:  atan_lut = 18'd917;
      4'd9:  atan_lut = 18'd458;
      4'd10: atan_lut = 18'd229;
      4'd11: atan_lut = 18'd115;
      4'd12: atan_lut = 18'd57;
      4'd13: atan_lut = 18'd29;
      4'd14: atan_lut = 18'd14;
      4'd15: atan_lut = 18'd7;
    endcase
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tp3_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds the saved pose stack; no dependencies.
`default_nettype none

module tp3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/tp3_dp.sv */
// Datapath of the turtle: pose registers, forward multiplier, CORDIC,
// square root, divider and pose stack. Depends on tp3_pkg and tp3_ram.
`default_nettype none

module tp3_dp #(
  parameter int STACK_DEPTH = tp3_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tp3_pkg::dp_cmd_t            cmd,
  input  logic [tp3_pkg::MODE_W-1:0]  in_mode,
  input  tp3_pkg::amt_t               in_amt,
  output tp3_pkg::dp_stat_t           stat,
  output logic [tp3_pkg::RES_W-1:0]   res
);

  localparam int CNTW  = $clog2(STACK_DEPTH + 1);
  localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int RAM_W = 3 * tp3_pkg::PW + 3 * tp3_pkg::HW;
  localparam int PW    = tp3_pkg::PW;
  localparam int LW    = tp3_pkg::LW;
  localparam int QW    = tp3_pkg::QW;
  localparam int EW    = tp3_pkg::EW;
  localparam int NW    = tp3_pkg::NW;

  logic [tp3_pkg::MODE_W-1:0] mode_q;
  tp3_pkg::amt_t  amt_q;
  tp3_pkg::z_t    z;
  tp3_pkg::pos_t  pos [3];
  tp3_pkg::head_t head [3];
  tp3_pkg::e_t    e [3];
  tp3_pkg::cv_t   u, v;
  logic signed [tp3_pkg::FPW-1:0] fprod;
  logic signed [tp3_pkg::GW-1:0]  gprod;
  tp3_pkg::sq_t   sq, sum, rrem, rres, rbit;
  tp3_pkg::rem_t  dr;
  logic [QW-1:0]  dn, dq;
  logic           dneg;
  logic [CNTW-1:0] cnt;
  logic           fault;

  logic [1:0]     ui, vi;
  logic           neg_ang;
  tp3_pkg::z_t    z_load, atan_z, z_fold;
  tp3_pkg::cv_t   hu, hv, du, dv, uv;
  logic [3:0]     sh;
  tp3_pkg::fw_t   fround;
  tp3_pkg::ps_t   psum;
  tp3_pkg::pos_t  psat;
  logic signed [2*EW-1:0] p2;
  tp3_pkg::sq_t   rtry;
  logic [EW-1:0]  mabs;
  tp3_pkg::num_t  num;
  tp3_pkg::rem_t  r2, lenx;
  logic [QW-1:0]  qc;
  logic [CNTW-1:0] cnt_m1;
  logic [CNTW+4:0] cnt_ext;
  logic            ram_we;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    unique case (tp3_pkg::mode_t'(in_mode))
      tp3_pkg::MODE_YAW_R, tp3_pkg::MODE_PITCH_UP, tp3_pkg::MODE_ROLL_L: neg_ang = 1'b1;
      default: neg_ang = 1'b0;
    endcase
    // Rotation plane (u toward v) for the latched command.
    unique case (tp3_pkg::mode_t'(mode_q))
      tp3_pkg::MODE_YAW_L, tp3_pkg::MODE_YAW_R: begin
        ui = 2'd2;
        vi = 2'd0;
      end
      tp3_pkg::MODE_PITCH_DN, tp3_pkg::MODE_PITCH_UP: begin
        ui = 2'd1;
        vi = 2'd2;
      end
      default: begin
        ui = 2'd0;
        vi = 2'd1;
      end
    endcase
  end

  assign z_load = neg_ang ? -tp3_pkg::z_t'(in_amt) : tp3_pkg::z_t'(in_amt);
  assign hu     = tp3_pkg::cv_t'(head[ui]) <<< 8;
  assign hv     = tp3_pkg::cv_t'(head[vi]) <<< 8;

  // Fold angles beyond a quarter turn back by a half turn, negating the pair.
  always_comb begin
    if (z > tp3_pkg::DEG90) begin
      z_fold = z - tp3_pkg::DEG180;
    end else if (z < tp3_pkg::NEG_DEG90) begin
      z_fold = z + tp3_pkg::DEG180;
    end else begin
      z_fold = z;
    end
  end

  assign sh     = cmd.step[3:0];
  assign du     = v >>> sh;
  assign dv     = u >>> sh;
  assign atan_z = tp3_pkg::z_t'(tp3_pkg::atan_lut(sh));
  assign uv     = cmd.idx[0] ? v : u;

  assign fround = (tp3_pkg::fw_t'(fprod) + tp3_pkg::fw_t'(2048)) >>> 12;
  assign psum   = tp3_pkg::ps_t'(pos[cmd.idx]) + tp3_pkg::ps_t'(fround);

  always_comb begin
    if (!psum[PW+1] && (psum[PW:PW-1] != 2'b00)) begin
      psat = {1'b0, {(PW-1){1'b1}}};
    end else if (psum[PW+1] && (psum[PW:PW-1] != 2'b11)) begin
      psat = {1'b1, {(PW-1){1'b0}}};
    end else begin
      psat = psum[PW-1:0];
    end
  end

  assign p2   = e[cmd.idx] * e[cmd.idx];
  assign rtry = rres + rbit;

  assign mabs = e[cmd.idx][EW-1] ? -e[cmd.idx] : e[cmd.idx];
  assign num  = tp3_pkg::num_t'({mabs, 16'b0}) + tp3_pkg::num_t'(rres[LW-1:1]);
  assign r2   = {dr[LW-1:0], dn[QW-1]};
  assign lenx = {1'b0, rres[LW-1:0]};
  assign qc   = (dq > tp3_pkg::Q_ONE) ? tp3_pkg::Q_ONE : dq;

  assign cnt_m1    = cnt - 1'b1;
  assign ram_we    = (cmd.op == tp3_pkg::OP_PUSH);
  assign ram_wdata = {pos[2], pos[1], pos[0], head[2], head[1], head[0]};

  tp3_ram #(
    .WIDTH(RAM_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt[AW-1:0]),
    .wdata(ram_wdata),
    .raddr(cnt_m1[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0]  <= '0;
      pos[1]  <= '0;
      pos[2]  <= '0;
      head[0] <= '0;
      head[1] <= tp3_pkg::HEAD_ONE;
      head[2] <= '0;
      cnt     <= '0;
      fault   <= 1'b0;
    end else begin
      unique case (cmd.op)
        tp3_pkg::OP_LOAD: begin
          mode_q <= in_mode;
          amt_q  <= in_amt;
          z      <= z_load;
          fault  <= 1'b0;
        end
        tp3_pkg::OP_FMUL: fprod <= head[cmd.idx] * amt_q;
        tp3_pkg::OP_FADD: pos[cmd.idx] <= psat;
        tp3_pkg::OP_REDUCE: begin
          if (z >= tp3_pkg::DEG180) begin
            z <= z - tp3_pkg::DEG360;
          end else begin
            z <= z + tp3_pkg::DEG360;
          end
        end
        tp3_pkg::OP_FOLD: begin
          e[0] <= tp3_pkg::e_t'(head[0]) <<< 8;
          e[1] <= tp3_pkg::e_t'(head[1]) <<< 8;
          e[2] <= tp3_pkg::e_t'(head[2]) <<< 8;
          z    <= z_fold;
          u    <= (z_fold != z) ? -hu : hu;
          v    <= (z_fold != z) ? -hv : hv;
          sq   <= '0;
          sum  <= '0;
        end
        tp3_pkg::OP_CORDIC: begin
          if (!z[tp3_pkg::ZW-1]) begin
            u <= u - du;
            v <= v + dv;
            z <= z - atan_z;
          end else begin
            u <= u + du;
            v <= v - dv;
            z <= z + atan_z;
          end
        end
        tp3_pkg::OP_GMUL: gprod <= uv * tp3_pkg::CORDIC_GAIN;
        tp3_pkg::OP_GWR: begin
          if (cmd.idx[0]) begin
            e[vi] <= gprod[16 +: EW];
          end else begin
            e[ui] <= gprod[16 +: EW];
          end
        end
        tp3_pkg::OP_SQ: begin
          sq  <= p2;
          sum <= sum + sq;
        end
        tp3_pkg::OP_SQACC: sum <= sum + sq;
        tp3_pkg::OP_RINIT: begin
          rrem <= sum;
          rres <= '0;
          rbit <= tp3_pkg::sq_t'(1) << (tp3_pkg::SW - 2);
        end
        tp3_pkg::OP_RSTEP: begin
          if (rrem >= rtry) begin
            rrem <= rrem - rtry;
            rres <= (rres >> 1) + rbit;
          end else begin
            rres <= rres >> 1;
          end
          rbit <= rbit >> 2;
        end
        tp3_pkg::OP_DINIT: begin
          // The quotient stays below 2^18, so the top bits start as remainder.
          dr   <= tp3_pkg::rem_t'(num[NW-1:QW]);
          dn   <= num[QW-1:0];
          dq   <= '0;
          dneg <= e[cmd.idx][EW-1];
        end
        tp3_pkg::OP_DSTEP: begin
          if (r2 >= lenx) begin
            dr <= r2 - lenx;
            dq <= {dq[QW-2:0], 1'b1};
          end else begin
            dr <= r2;
            dq <= {dq[QW-2:0], 1'b0};
          end
          dn <= {dn[QW-2:0], 1'b0};
        end
        tp3_pkg::OP_DWR: head[cmd.idx] <= dneg ? -tp3_pkg::head_t'(qc) : tp3_pkg::head_t'(qc);
        tp3_pkg::OP_NEG: begin
          head[0] <= -head[0];
          head[1] <= -head[1];
          head[2] <= -head[2];
        end
        tp3_pkg::OP_PUSH:   cnt <= cnt + 1'b1;
        tp3_pkg::OP_POP_RD: cnt <= cnt_m1;
        tp3_pkg::OP_POP_WR: begin
          {pos[2], pos[1], pos[0], head[2], head[1], head[0]} <= ram_rdata;
        end
        tp3_pkg::OP_FAULT: fault <= 1'b1;
        default: ;
      endcase
    end
  end

  assign stat.red_done  = (z < tp3_pkg::DEG180) && (z >= tp3_pkg::NEG_DEG180);
  assign stat.len_zero  = (rres == '0);
  assign stat.stk_full  = (cnt == CNTW'(STACK_DEPTH));
  assign stat.stk_empty = (cnt == '0);

  assign cnt_ext = {5'b0, cnt};
  assign res = {cnt_ext[4:0], fault, head[2], head[1], head[0], pos[2], pos[1], pos[0]};

endmodule

`default_nettype wire

/* rtl/core/tp3_ctrl.sv */
// Controller state machine that sequences the turtle datapath per command.
// Depends on tp3_pkg.
`default_nettype none

module tp3_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [tp3_pkg::MODE_W-1:0] in_mode,
  input  logic                       out_free,
  input  tp3_pkg::dp_stat_t          stat,
  output logic                       in_ready,
  output tp3_pkg::dp_cmd_t           cmd,
  output logic                       out_load
);

  tp3_pkg::state_t state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tp3_pkg::ST_IDLE;
      cnt   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    cmd.op     = tp3_pkg::OP_NOP;
    cmd.idx    = idx;
    cmd.step   = cnt;
    out_load   = 1'b0;
    in_ready   = 1'b0;
    unique case (state)
      tp3_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.op   = tp3_pkg::OP_LOAD;
          cnt_next = '0;
          idx_next = '0;
          unique case (tp3_pkg::mode_t'(in_mode))
            tp3_pkg::MODE_FWD: state_next = tp3_pkg::ST_FMUL;
            tp3_pkg::MODE_YAW_L, tp3_pkg::MODE_YAW_R, tp3_pkg::MODE_PITCH_DN,
            tp3_pkg::MODE_PITCH_UP, tp3_pkg::MODE_ROLL_L,
            tp3_pkg::MODE_ROLL_R: state_next = tp3_pkg::ST_RED;
            tp3_pkg::MODE_TURN: state_next = tp3_pkg::ST_NEG;
            tp3_pkg::MODE_PUSH: state_next = tp3_pkg::ST_PUSH;
            tp3_pkg::MODE_POP:  state_next = tp3_pkg::ST_POP;
            default:            state_next = tp3_pkg::ST_OUT;
          endcase
        end
      end
      tp3_pkg::ST_FMUL: begin
        cmd.op     = tp3_pkg::OP_FMUL;
        state_next = tp3_pkg::ST_FADD;
      end
      tp3_pkg::ST_FADD: begin
        cmd.op = tp3_pkg::OP_FADD;
        if (idx == tp3_pkg::AXIS_LAST) begin
          state_next = tp3_pkg::ST_OUT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = tp3_pkg::ST_FMUL;
        end
      end
      tp3_pkg::ST_RED: begin
        // One full turn per cycle until the angle lies in [-180, 180).
        if (stat.red_done) begin
          cmd.op     = tp3_pkg::OP_FOLD;
          cnt_next   = '0;
          state_next = tp3_pkg::ST_CORD;
        end else begin
          cmd.op = tp3_pkg::OP_REDUCE;
        end
      end
      tp3_pkg::ST_CORD: begin
        cmd.op = tp3_pkg::OP_CORDIC;
        if (cnt == tp3_pkg::CORDIC_LAST) begin
          cnt_next   = '0;
          state_next = tp3_pkg::ST_GAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tp3_pkg::ST_GAIN: begin
        cmd.idx = {1'b0, cnt[1]};
        cmd.op  = cnt[0] ? tp3_pkg::OP_GWR : tp3_pkg::OP_GMUL;
        if (cnt == tp3_pkg::GAIN_LAST) begin
          cnt_next   = '0;
          state_next = tp3_pkg::ST_SQ;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tp3_pkg::ST_SQ: begin
        cmd.idx = cnt[1:0];
        if (cnt == tp3_pkg::SQ_LAST) begin
          cmd.op     = tp3_pkg::OP_SQACC;
          state_next = tp3_pkg::ST_RINIT;
        end else begin
          cmd.op   = tp3_pkg::OP_SQ;
          cnt_next = cnt + 1'b1;
        end
      end
      tp3_pkg::ST_RINIT: begin
        cmd.op     = tp3_pkg::OP_RINIT;
        cnt_next   = '0;
        state_next = tp3_pkg::ST_ROOT;
      end
      tp3_pkg::ST_ROOT: begin
        cmd.op = tp3_pkg::OP_RSTEP;
        if (cnt == tp3_pkg::ROOT_LAST) begin
          state_next = tp3_pkg::ST_DCHK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tp3_pkg::ST_DCHK: begin
        // A zero length keeps the old heading.
        idx_next   = '0;
        state_next = stat.len_zero ? tp3_pkg::ST_OUT : tp3_pkg::ST_DINIT;
      end
      tp3_pkg::ST_DINIT: begin
        cmd.op     = tp3_pkg::OP_DINIT;
        cnt_next   = '0;
        state_next = tp3_pkg::ST_DIV;
      end
      tp3_pkg::ST_DIV: begin
        cmd.op = tp3_pkg::OP_DSTEP;
        if (cnt == tp3_pkg::DIV_LAST) begin
          state_next = tp3_pkg::ST_DWR;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tp3_pkg::ST_DWR: begin
        cmd.op = tp3_pkg::OP_DWR;
        if (idx == tp3_pkg::AXIS_LAST) begin
          state_next = tp3_pkg::ST_OUT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = tp3_pkg::ST_DINIT;
        end
      end
      tp3_pkg::ST_NEG: begin
        cmd.op     = tp3_pkg::OP_NEG;
        state_next = tp3_pkg::ST_OUT;
      end
      tp3_pkg::ST_PUSH: begin
        cmd.op     = stat.stk_full ? tp3_pkg::OP_FAULT : tp3_pkg::OP_PUSH;
        state_next = tp3_pkg::ST_OUT;
      end
      tp3_pkg::ST_POP: begin
        if (stat.stk_empty) begin
          cmd.op     = tp3_pkg::OP_FAULT;
          state_next = tp3_pkg::ST_OUT;
        end else begin
          cmd.op     = tp3_pkg::OP_POP_RD;
          state_next = tp3_pkg::ST_POPW;
        end
      end
      tp3_pkg::ST_POPW: begin
        cmd.op     = tp3_pkg::OP_POP_WR;
        state_next = tp3_pkg::ST_OUT;
      end
      tp3_pkg::ST_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = tp3_pkg::ST_IDLE;
        end
      end
      default: state_next = tp3_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/turtle_3d_pose_interpreter.sv */
// Three-dimensional turtle: takes one command per transfer and returns the pose after it.
// Depends on tp3_pkg, tp3_ctrl, tp3_dp (and tp3_ram beneath it).
//
// The block works on one command at a time and returns exactly one result
// transfer for each command. Forward uses one shared 18x24 multiplier and
// updates the three axes one after another. Yaw, pitch and roll reduce the
// angle by whole turns, fold it, then run 16 CORDIC iterations, the gain
// multiplier, the sum of squares, the bit-serial square root, the
// zero-length check and the shared restoring divider that renormalizes the
// three heading components one after another. A new command is accepted
// the cycle after a result enters the output register, even while that
// result still waits to be taken. The pose stack is a RAM of STACK_DEPTH
// entries; it needs no clearing after reset.
`default_nettype none

module turtle_3d_pose_interpreter #(
  parameter int STACK_DEPTH = tp3_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [23:0]                        s_axis_tdata,  // [23:0] amount
  input  logic [3:0]                         s_axis_tuser,  // [3:0] mode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [113:96] head_x,
  // [131:114] head_y, [149:132] head_z, [150] stack_fault,
  // [155:151] saved_count, [159:156] zero
  output logic [tp3_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  tp3_pkg::dp_cmd_t  cmd;
  tp3_pkg::dp_stat_t stat;
  logic [tp3_pkg::RES_W-1:0] res;
  logic out_load;
  logic out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  tp3_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_mode (s_axis_tuser),
    .out_free(out_free),
    .stat    (stat),
    .in_ready(s_axis_tready),
    .cmd     (cmd),
    .out_load(out_load)
  );

  tp3_dp #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .in_mode(s_axis_tuser),
    .in_amt (s_axis_tdata),
    .stat   (stat),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {{(tp3_pkg::OUT_DATA_W - tp3_pkg::RES_W){1'b0}}, res};
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over an untaken result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second command accepted while busy");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_axis_tvalid)
    else $error("loaded result not presented");

  a_stack_count: assert property (@(posedge clk) disable iff (rst)
    !(stat.stk_full && stat.stk_empty))
    else $error("stack reported full and empty at once");

endmodule

`default_nettype wire
